>>> rtl/core/lpc_pkg.sv
package lpc_pkg;

    localparam int NUM_PAGES_DEF  = 16;
    localparam int PAGE_WORDS_DEF = 8;
    localparam int TAG_W          = 64;
    localparam int WORD_W         = 32;
    localparam int CMD_W          = 3;
    localparam int WIDX_W         = 4;
    localparam int RIDX_W         = 3;
    localparam int DTOT_W         = 5;
    localparam int CFG_W          = 5;
    localparam int CFG_RESET      = 16;
    localparam int S_TDATA_W      = 104;
    localparam int M_TDATA_W      = 112;

    localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLUSH_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INVAL     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DCOUNT    = 3'd5;

    typedef enum logic [2:0] {
        DIR_NOP,
        DIR_TOUCH,
        DIR_WTOUCH,
        DIR_ALLOC,
        DIR_DROP,
        DIR_CLEAN,
        DIR_CLEAN_ALL
    } dir_op_t;

    typedef struct packed {
        logic hit;
        logic free_any;
        logic lru_dirty;
    } dir_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_ALLOC,
        ST_FILL,
        ST_RDREQ,
        ST_RDDATA,
        ST_RESP
    } state_t;

endpackage

>>> rtl/core/lru_page_cache.sv
// Each command takes one beat in, then the lookup state ST_LOOK and, but for a read hit,
// the response state ST_RESP. A write miss adds ST_ALLOC and ST_FILL, zeroing the page
// in the page memory; a read hit gives PAGE_WORDS beats, each a read in ST_RDREQ and then
// its registered data in ST_RDDATA. One command is in flight at a time.
// Reset clears all valid, dirty and age state at once and sets cfg_reg to 16;
// page data and tags are not cleared, since they are only read after being written.
module lru_page_cache
    import lpc_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_WORDS = PAGE_WORDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // page_id[63:0], word_index[67:64], write_word[99:68]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[2:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found[0], ok[1], read_word[33:2], read_index[36:34], dirty_total[41:37],
    // evicted[42], evicted_page_id[106:43], evicted_dirty[107]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int SW    = $clog2(NUM_PAGES);
    localparam int DEPTH = NUM_PAGES * PAGE_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WCW   = $clog2(PAGE_WORDS + 1);

    function automatic logic [M_TDATA_W-1:0] pack_out(
        input logic              found,
        input logic              ok,
        input logic [WORD_W-1:0] rw,
        input logic [RIDX_W-1:0] ri,
        input logic [DTOT_W-1:0] dt,
        input logic              ev,
        input logic [TAG_W-1:0]  eid,
        input logic              ed
    );
        return {4'b0, ed, eid, ev, dt, ri, rw, ok, found};
    endfunction

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [TAG_W-1:0]     id_reg, id_next;
    logic [WIDX_W-1:0]    widx_reg, widx_next;
    logic [WORD_W-1:0]    data_reg, data_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [WCW-1:0]       wcnt_reg, wcnt_next;
    logic                 rsp_found_reg, rsp_found_next;
    logic                 rsp_ok_reg, rsp_ok_next;
    logic [DTOT_W-1:0]    rsp_dt_reg, rsp_dt_next;
    logic                 ev_reg, ev_next;
    logic [TAG_W-1:0]     evid_reg, evid_next;
    logic                 evd_reg, evd_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    dir_op_t              dir_op;
    logic [SW-1:0]        dir_slot;
    logic [NUM_PAGES-1:0] hit_vec;
    logic [SW-1:0]        hit_idx, lru_idx, free_idx;
    logic [TAG_W-1:0]     lru_tag;
    logic [SW:0]          vcount, dcount;
    dir_flags_t           flags;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_W-1:0]    mem_wdata, mem_rdata;

    logic                 s_accept, out_free, widx_bad, need_evict, reject, last_word;
    logic [31:0]          cap;
    logic [SW-1:0]        alloc_slot;
    logic [AW-1:0]        word_addr;

    lpc_dir #(.NUM_PAGES(NUM_PAGES)) u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (dir_op),
        .op_slot  (dir_slot),
        .op_tag   (id_reg),
        .look_tag (id_reg),
        .hit_vec  (hit_vec),
        .hit_idx  (hit_idx),
        .lru_idx  (lru_idx),
        .lru_tag  (lru_tag),
        .free_idx (free_idx),
        .vcount   (vcount),
        .dcount   (dcount),
        .flags    (flags)
    );

    lpc_ram #(.DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cap = 32'd1;
        end
        else if (32'(cfg_reg) > 32'(NUM_PAGES))
        begin
            cap = 32'(NUM_PAGES);
        end
        else
        begin
            cap = 32'(cfg_reg);
        end
        widx_bad   = 32'(widx_reg) >= 32'(PAGE_WORDS);
        need_evict = 32'(vcount) >= cap;
        reject     = need_evict && (32'(vcount) - 32'd1 >= cap);
        if (!need_evict)
        begin
            alloc_slot = free_idx;
        end
        else if (!flags.free_any || lru_idx < free_idx)
        begin
            alloc_slot = lru_idx;
        end
        else
        begin
            alloc_slot = free_idx;
        end
        last_word = wcnt_reg == WCW'(PAGE_WORDS - 1);
        word_addr = AW'(AW'(slot_reg) * AW'(PAGE_WORDS) + AW'(wcnt_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (cmd_reg == CMD_READ && flags.hit)
                begin
                    state_next = ST_RDREQ;
                end
                else if (cmd_reg == CMD_WRITE && !widx_bad && !flags.hit && !reject)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_ALLOC:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (last_word)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RDREQ:
            begin
                if (out_free)
                begin
                    state_next = ST_RDDATA;
                end
            end
            ST_RDDATA:
            begin
                state_next = last_word ? ST_IDLE : ST_RDREQ;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        widx_next      = widx_reg;
        data_next      = data_reg;
        slot_next      = slot_reg;
        wcnt_next      = wcnt_reg;
        rsp_found_next = rsp_found_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_dt_next    = rsp_dt_reg;
        ev_next        = ev_reg;
        evid_next      = evid_reg;
        evd_next       = evd_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        dir_op         = DIR_NOP;
        dir_slot       = hit_idx;
        mem_we         = 1'b0;
        mem_waddr      = word_addr;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = word_addr;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next  = s_tuser;
                    id_next   = s_tdata[63:0];
                    widx_next = s_tdata[67:64];
                    data_next = s_tdata[99:68];
                    ev_next   = 1'b0;
                    evid_next = '0;
                    evd_next  = 1'b0;
                end
            end
            ST_LOOK:
            begin
                rsp_found_next = flags.hit;
                rsp_ok_next    = 1'b0;
                rsp_dt_next    = '0;
                wcnt_next      = '0;
                slot_next      = hit_idx;
                case (cmd_reg)
                    CMD_READ:
                    begin
                        rsp_found_next = 1'b0;
                        if (flags.hit)
                        begin
                            dir_op = DIR_TOUCH;
                        end
                    end
                    CMD_WRITE:
                    begin
                        if (widx_bad)
                        begin
                            rsp_ok_next = 1'b0;
                        end
                        else if (flags.hit)
                        begin
                            dir_op      = DIR_WTOUCH;
                            rsp_ok_next = 1'b1;
                            mem_we      = 1'b1;
                            mem_waddr   = AW'(AW'(hit_idx) * AW'(PAGE_WORDS) + AW'(widx_reg));
                            mem_wdata   = data_reg;
                        end
                        else
                        begin
                            slot_next   = alloc_slot;
                            rsp_ok_next = !reject;
                            if (need_evict)
                            begin
                                dir_op    = DIR_DROP;
                                dir_slot  = lru_idx;
                                ev_next   = 1'b1;
                                evid_next = lru_tag;
                                evd_next  = flags.lru_dirty;
                            end
                        end
                    end
                    CMD_FLUSH:
                    begin
                        rsp_ok_next = flags.hit;
                        if (flags.hit)
                        begin
                            dir_op = DIR_CLEAN;
                        end
                    end
                    CMD_FLUSH_ALL:
                    begin
                        rsp_found_next = 1'b0;
                        rsp_ok_next    = 1'b1;
                        dir_op         = DIR_CLEAN_ALL;
                    end
                    CMD_INVAL:
                    begin
                        rsp_ok_next = 1'b1;
                        if (flags.hit)
                        begin
                            dir_op = DIR_DROP;
                        end
                    end
                    CMD_DCOUNT:
                    begin
                        rsp_found_next = 1'b0;
                        rsp_ok_next    = 1'b1;
                        rsp_dt_next    = DTOT_W'(dcount);
                    end
                    default:
                    begin
                        rsp_found_next = 1'b0;
                    end
                endcase
            end
            ST_ALLOC:
            begin
                dir_op   = DIR_ALLOC;
                dir_slot = slot_reg;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = (32'(wcnt_reg) == 32'(widx_reg)) ? data_reg : '0;
                wcnt_next = wcnt_reg + 1'b1;
            end
            ST_RDREQ:
            begin
                mem_re = out_free;
            end
            ST_RDDATA:
            begin
                out_valid_next = 1'b1;
                out_last_next  = last_word;
                out_data_next  = pack_out(1'b1, 1'b1, mem_rdata, RIDX_W'(wcnt_reg), '0,
                                          1'b0, '0, 1'b0);
                wcnt_next      = wcnt_reg + 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_data_next  = pack_out(rsp_found_reg, rsp_ok_reg, '0, '0, rsp_dt_reg,
                                              ev_reg, evid_reg, evd_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        widx_reg      <= widx_next;
        data_reg      <= data_next;
        slot_reg      <= slot_next;
        wcnt_reg      <= wcnt_next;
        rsp_found_reg <= rsp_found_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_dt_reg    <= rsp_dt_next;
        ev_reg        <= ev_next;
        evid_reg      <= evid_next;
        evd_reg       <= evd_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg       <= CFG_W'(CFG_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    a_dirty_le_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dcount <= vcount)
        else $error("dirty count exceeds valid count");

    a_valid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(vcount) <= 32'(NUM_PAGES))
        else $error("valid count exceeds cache size");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("page matches more than one entry");

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
        else $error("new command taken in the middle of a read run");

endmodule

>>> rtl/core/lpc_ram.sv
module lpc_ram
    import lpc_pkg::*;
#(
    parameter int DEPTH = NUM_PAGES_DEF * PAGE_WORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/lpc_dir.sv
module lpc_dir
    import lpc_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int SW        = $clog2(NUM_PAGES)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dir_op_t              op,
    input  logic [SW-1:0]        op_slot,
    input  logic [TAG_W-1:0]     op_tag,
    input  logic [TAG_W-1:0]     look_tag,
    output logic [NUM_PAGES-1:0] hit_vec,
    output logic [SW-1:0]        hit_idx,
    output logic [SW-1:0]        lru_idx,
    output logic [TAG_W-1:0]     lru_tag,
    output logic [SW-1:0]        free_idx,
    output logic [SW:0]          vcount,
    output logic [SW:0]          dcount,
    output dir_flags_t           flags
);

    logic [NUM_PAGES-1:0] valid_reg;
    logic [NUM_PAGES-1:0] dirty_reg;
    logic [SW-1:0]        age_reg [NUM_PAGES];
    logic [TAG_W-1:0]     tag_reg [NUM_PAGES];
    logic [SW:0]          vcount_reg;
    logic [SW:0]          dcount_reg;
    logic [SW-1:0]        slot_age;
    logic [NUM_PAGES-1:0] lru_vec;

    assign slot_age = age_reg[op_slot];

    always_comb
    begin
        hit_idx  = '0;
        lru_idx  = '0;
        free_idx = '0;
        flags.free_any = 1'b0;
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (tag_reg[i] == look_tag);
            lru_vec[i] = valid_reg[i] && ({1'b0, age_reg[i]} == vcount_reg - 1'b1);
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | SW'(i);
            end
            if (lru_vec[i])
            begin
                lru_idx = lru_idx | SW'(i);
            end
        end
        for (int i = NUM_PAGES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx       = SW'(i);
                flags.free_any = 1'b1;
            end
        end
        flags.hit       = |hit_vec;
        flags.lru_dirty = dirty_reg[lru_idx];
        lru_tag         = tag_reg[lru_idx];
    end

    assign vcount = vcount_reg;
    assign dcount = dcount_reg;

    always_ff @(posedge clk)
    begin
        if (op == DIR_ALLOC)
        begin
            tag_reg[op_slot] <= op_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= '0;
            vcount_reg <= '0;
            dcount_reg <= '0;
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            case (op)
                DIR_TOUCH, DIR_WTOUCH:
                begin
                    for (int i = 0; i < NUM_PAGES; i++)
                    begin
                        if (op_slot != SW'(i) && valid_reg[i] && age_reg[i] < slot_age)
                        begin
                            age_reg[i] <= age_reg[i] + 1'b1;
                        end
                    end
                    age_reg[op_slot] <= '0;
                    if (op == DIR_WTOUCH)
                    begin
                        dirty_reg[op_slot] <= 1'b1;
                        if (!dirty_reg[op_slot])
                        begin
                            dcount_reg <= dcount_reg + 1'b1;
                        end
                    end
                end
                DIR_ALLOC:
                begin
                    for (int i = 0; i < NUM_PAGES; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            age_reg[i] <= age_reg[i] + 1'b1;
                        end
                    end
                    valid_reg[op_slot] <= 1'b1;
                    dirty_reg[op_slot] <= 1'b1;
                    age_reg[op_slot]   <= '0;
                    vcount_reg         <= vcount_reg + 1'b1;
                    dcount_reg         <= dcount_reg + 1'b1;
                end
                DIR_DROP:
                begin
                    for (int i = 0; i < NUM_PAGES; i++)
                    begin
                        if (op_slot != SW'(i) && valid_reg[i] && age_reg[i] > slot_age)
                        begin
                            age_reg[i] <= age_reg[i] - 1'b1;
                        end
                    end
                    valid_reg[op_slot] <= 1'b0;
                    dirty_reg[op_slot] <= 1'b0;
                    age_reg[op_slot]   <= '0;
                    vcount_reg         <= vcount_reg - 1'b1;
                    if (dirty_reg[op_slot])
                    begin
                        dcount_reg <= dcount_reg - 1'b1;
                    end
                end
                DIR_CLEAN:
                begin
                    dirty_reg[op_slot] <= 1'b0;
                    if (dirty_reg[op_slot])
                    begin
                        dcount_reg <= dcount_reg - 1'b1;
                    end
                end
                DIR_CLEAN_ALL:
                begin
                    dirty_reg  <= '0;
                    dcount_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
